FILE: hdl/sbfp_pkg.sv
// shared types, codes and result builder for the serial bridge frame parser
package sbfp_pkg;

	localparam logic [7:0] OP_IDENT = 8'h12;
	localparam logic [7:0] OP_QUIET = 8'h13;
	localparam logic [7:0] OP_START = 8'hA5;
	localparam logic [7:0] RSP_IDENT = 8'h5B;
	localparam logic [7:0] RSP_ACK = 8'hAC;
	localparam logic [7:0] RSP_NACK = 8'h5A;
	localparam logic [7:0] TYPE_WRITE_BLOCK = 8'h03;

	// index of the final header byte (header is 12 bytes)
	localparam logic [3:0] HDR_LAST_IDX = 4'd11;

	localparam logic [15:0] LIMIT_RESET = 16'd256;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_RSP = 2'd0;
	localparam kind_t KIND_REQ = 2'd1;
	localparam kind_t KIND_DATA = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data_byte;
		logic [7:0] req_type;
		logic [15:0] req_size;
		logic [31:0] req_address;
		logic [31:0] req_value;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t first;
		result_t second;
	} parse_out_t;

	function automatic result_t make_result(
		input kind_t kind,
		input logic [7:0] data_byte,
		input logic with_req,
		input logic last,
		input logic [7:0] req_type,
		input logic [15:0] req_size,
		input logic [31:0] req_address,
		input logic [31:0] req_value
	);
		result_t r;
		r.kind = kind;
		r.data_byte = data_byte;
		r.req_type = with_req ? req_type : 8'd0;
		r.req_size = with_req ? req_size : 16'd0;
		r.req_address = with_req ? req_address : 32'd0;
		r.req_value = with_req ? req_value : 32'd0;
		r.last = last;
		return r;
	endfunction

endpackage

FILE: hdl/sbfp_ifs.sv
// valid/ready channel interfaces for received bytes and parser results
interface sbfp_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfp_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] req_type;
	logic [15:0] req_size;
	logic [31:0] req_address;
	logic [31:0] req_value;
	logic last;

	modport source (
		output valid, output kind, output data_byte, output req_type, output req_size,
		output req_address, output req_value, output last, input ready
	);
	modport sink (
		input valid, input kind, input data_byte, input req_type, input req_size,
		input req_address, input req_value, input last, output ready
	);
endinterface

FILE: hdl/serial_bridge_frame_parser.sv
// top level: byte parser with a two-entry result register and config register
// output: the first result of a byte is registered and appears at the output in the cycle after the byte is accepted
// throughput: one byte per cycle while the output is ready and each byte
// makes at most one result; a byte that makes two results blocks the input
// until the single output port has moved its second result out of the second slot
// reset: phase idle, counters and held header cleared, payload_limit 256, no results
module serial_bridge_frame_parser (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [15:0] cfg_data,
	sbfp_in_if.sink in_ch,
	sbfp_out_if.source out_ch
);

	logic [15:0] payload_limit_q;
	sbfp_pkg::parse_out_t res;
	sbfp_pkg::result_t out_q;
	sbfp_pkg::result_t ext_q;
	logic out_valid_q;
	logic ext_valid_q;
	logic accept;
	logic pop;

	// second slot holds the extra result of a two-result byte
	assign in_ch.ready = !ext_valid_q && (!out_valid_q || out_ch.ready);
	assign accept = in_ch.valid && in_ch.ready;
	assign pop = out_valid_q && out_ch.ready;

	sbfp_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(in_ch.rx_byte),
		.payload_limit(payload_limit_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q <= sbfp_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			payload_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ext_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= (res.count != 2'd0);
			ext_valid_q <= (res.count == 2'd2);
		end else if (pop) begin
			out_valid_q <= ext_valid_q;
			ext_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res.first;
			ext_q <= res.second;
		end else if (pop) begin
			out_q <= ext_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = out_q.kind;
	assign out_ch.data_byte = out_q.data_byte;
	assign out_ch.req_type = out_q.req_type;
	assign out_ch.req_size = out_q.req_size;
	assign out_ch.req_address = out_q.req_address;
	assign out_ch.req_value = out_q.req_value;
	assign out_ch.last = out_q.last;

endmodule

FILE: hdl/sbfp_core.sv
// frame parsing state and per-byte result decode
module sbfp_core (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] rx_byte,
	input logic [15:0] payload_limit,
	output sbfp_pkg::parse_out_t res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0] phase_q, phase_n;
	logic [15:0] byte_count_q, byte_count_n;
	logic [7:0] running_xor_q, running_xor_n;
	logic [7:0] held_type_q, held_type_n;
	logic [15:0] held_size_q, held_size_n;
	logic [31:0] held_address_q, held_address_n;
	logic [31:0] held_value_q, held_value_n;

	logic [15:0] count_inc;
	logic is_wb;
	logic refuse;

	assign count_inc = byte_count_q + 16'd1;

	always_comb begin
		phase_n = phase_q;
		byte_count_n = byte_count_q;
		running_xor_n = running_xor_q;
		held_type_n = held_type_q;
		held_size_n = held_size_q;
		held_address_n = held_address_q;
		held_value_n = held_value_q;
		is_wb = 1'b0;
		refuse = 1'b0;
		res.count = 2'd0;
		res.first = sbfp_pkg::make_result(sbfp_pkg::KIND_RSP, 8'd0, 1'b0, 1'b1,
			8'd0, 16'd0, 32'd0, 32'd0);
		res.second = res.first;

		unique case (phase_q)
			PH_HEADER: begin
				running_xor_n = running_xor_q ^ rx_byte;
				case (byte_count_q[3:0])
					4'd0: held_type_n = rx_byte;
					4'd2: held_size_n[7:0] = rx_byte;
					4'd3: held_size_n[15:8] = rx_byte;
					4'd4: held_address_n[7:0] = rx_byte;
					4'd5: held_address_n[15:8] = rx_byte;
					4'd6: held_address_n[23:16] = rx_byte;
					4'd7: held_address_n[31:24] = rx_byte;
					4'd8: held_value_n[7:0] = rx_byte;
					4'd9: held_value_n[15:8] = rx_byte;
					4'd10: held_value_n[23:16] = rx_byte;
					4'd11: held_value_n[31:24] = rx_byte;
					default: ;
				endcase
				byte_count_n = count_inc;
				if (byte_count_q[3:0] == sbfp_pkg::HDR_LAST_IDX) begin
					is_wb = (held_type_n == sbfp_pkg::TYPE_WRITE_BLOCK);
					refuse = (running_xor_n != 8'd0) || (is_wb && (held_size_n > payload_limit));
					byte_count_n = 16'd0;
					res.count = 2'd1;
					if (refuse) begin
						phase_n = PH_IDLE;
						res.first.data_byte = sbfp_pkg::RSP_NACK;
					end else if (is_wb && (held_size_n != 16'd0)) begin
						phase_n = PH_PAYLOAD;
						res.first.data_byte = sbfp_pkg::RSP_ACK;
					end else begin
						// ack and the request come from the same byte
						phase_n = PH_IDLE;
						res.count = 2'd2;
						res.first.data_byte = sbfp_pkg::RSP_ACK;
						res.first.last = 1'b0;
						res.second = sbfp_pkg::make_result(sbfp_pkg::KIND_REQ, 8'd0, 1'b1,
							1'b1, held_type_n, held_size_n, held_address_n, held_value_n);
					end
				end
			end
			PH_PAYLOAD: begin
				res.first = sbfp_pkg::make_result(sbfp_pkg::KIND_DATA, rx_byte, 1'b0, 1'b1,
					8'd0, 16'd0, 32'd0, 32'd0);
				res.count = 2'd1;
				byte_count_n = count_inc;
				if (count_inc >= held_size_q) begin
					phase_n = PH_IDLE;
					byte_count_n = 16'd0;
					res.count = 2'd2;
					res.first.last = 1'b0;
					res.second = sbfp_pkg::make_result(sbfp_pkg::KIND_REQ, 8'd0, 1'b1,
						1'b1, held_type_q, held_size_q, held_address_q, held_value_q);
				end
			end
			default: begin
				// idle, and the unused phase code behaves the same
				phase_n = PH_IDLE;
				case (rx_byte)
					sbfp_pkg::OP_IDENT: begin
						res.count = 2'd1;
						res.first.data_byte = sbfp_pkg::RSP_IDENT;
					end
					sbfp_pkg::OP_START: begin
						phase_n = PH_HEADER;
						byte_count_n = 16'd0;
						running_xor_n = 8'd0;
					end
					sbfp_pkg::OP_QUIET: ;
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			byte_count_q <= 16'd0;
			running_xor_q <= 8'd0;
			held_type_q <= 8'd0;
			held_size_q <= 16'd0;
			held_address_q <= 32'd0;
			held_value_q <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			byte_count_q <= byte_count_n;
			running_xor_q <= running_xor_n;
			held_type_q <= held_type_n;
			held_size_q <= held_size_n;
			held_address_q <= held_address_n;
			held_value_q <= held_value_n;
		end
	end

endmodule
